### rtl/lse_pkg.sv
`timescale 1ns / 1ps

package lse_pkg;

  localparam int BUFFER_BITS = 32;
  localparam int FILL_W      = $clog2(BUFFER_BITS + 1);

  typedef enum logic [2:0] {
    ST_EMBEDDED = 3'd0,
    ST_DONE     = 3'd1,
    ST_UNDERRUN = 3'd2,
    ST_BYTE_OK  = 3'd3,
    ST_BYTE_REJ = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_RED_BITS   = 2'd0,
    REG_GREEN_BITS = 2'd1,
    REG_BLUE_BITS  = 2'd2
  } reg_index_t;

  localparam logic [3:0] BITS_RESET = 4'd3;

  typedef struct packed {
    logic       action;
    logic [7:0] message_byte;
    logic       message_last;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    status_t    status;
  } out_item_t;

  typedef struct packed {
    logic [3:0] red_bits;
    logic [3:0] green_bits;
    logic [3:0] blue_bits;
  } cfg_t;

  typedef struct packed {
    logic [BUFFER_BITS-1:0] buffer;
    logic [FILL_W-1:0]      fill;
    logic                   done;
  } msg_state_t;

endpackage

### rtl/lse_embed.sv
`timescale 1ns / 1ps

module lse_embed (
  input  lse_pkg::cfg_t       cfg,
  input  lse_pkg::msg_state_t st,
  input  lse_pkg::in_item_t   item,
  output lse_pkg::out_item_t  result,
  output lse_pkg::msg_state_t st_next
);

  localparam int BB = lse_pkg::BUFFER_BITS;
  localparam int FW = lse_pkg::FILL_W;
  localparam logic [FW-1:0] FULL_FILL = FW'(BB);
  localparam logic [FW-1:0] PUSH_LIMIT = FW'(BB - 8);

  logic [3:0]    kr, kg, kb;
  logic [FW-1:0] need;
  logic [FW-1:0] fill_left;
  logic [BB-1:0] aligned, after_r, after_g;
  logic [7:0]    top_r, top_g, top_b;
  logic [7:0]    mask_r, mask_g, mask_b;
  logic [7:0]    emb_r, emb_g, emb_b;

  assign kr = (cfg.red_bits   > 4'd8) ? 4'd8 : cfg.red_bits;
  assign kg = (cfg.green_bits > 4'd8) ? 4'd8 : cfg.green_bits;
  assign kb = (cfg.blue_bits  > 4'd8) ? 4'd8 : cfg.blue_bits;
  assign need = FW'(kr) + FW'(kg) + FW'(kb);

  // The oldest pending bit is moved to the top; missing bits read as zero.
  assign aligned = st.buffer << (FULL_FILL - st.fill);
  assign after_r = aligned << kr;
  assign after_g = after_r << kg;
  assign top_r = aligned[BB-1 -: 8];
  assign top_g = after_r[BB-1 -: 8];
  assign top_b = after_g[BB-1 -: 8];

  assign mask_r = 8'hFF >> (4'd8 - kr);
  assign mask_g = 8'hFF >> (4'd8 - kg);
  assign mask_b = 8'hFF >> (4'd8 - kb);

  assign emb_r = (item.red_in   & ~mask_r) | (top_r >> (4'd8 - kr));
  assign emb_g = (item.green_in & ~mask_g) | (top_g >> (4'd8 - kg));
  assign emb_b = (item.blue_in  & ~mask_b) | (top_b >> (4'd8 - kb));

  assign fill_left = (st.fill >= need) ? (st.fill - need) : '0;

  always_comb begin
    st_next          = st;
    result.red_out   = item.red_in;
    result.green_out = item.green_in;
    result.blue_out  = item.blue_in;
    result.status    = lse_pkg::ST_UNDERRUN;
    case (item.action)
      1'b0: begin
        result.red_out   = '0;
        result.green_out = '0;
        result.blue_out  = '0;
        if (st.done || (st.fill > PUSH_LIMIT)) begin
          result.status = lse_pkg::ST_BYTE_REJ;
        end else begin
          result.status = lse_pkg::ST_BYTE_OK;
          st_next.buffer = {st.buffer[BB-9:0], item.message_byte};
          st_next.fill   = st.fill + FW'(8);
          st_next.done   = item.message_last;
        end
      end
      default: begin
        if (st.done && (st.fill == '0)) begin
          result.status = lse_pkg::ST_DONE;
        end else if ((st.fill >= need) || st.done) begin
          result.red_out   = emb_r;
          result.green_out = emb_g;
          result.blue_out  = emb_b;
          result.status    = lse_pkg::ST_EMBEDDED;
          st_next.fill     = fill_left;
          st_next.buffer   = st.buffer & ~({BB{1'b1}} << fill_left);
        end
      end
    endcase
  end

endmodule

### rtl/lsb_stego_pixel_embed_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   lse_pkg::in_item_t (byte push or pixel)
// out       output     out_valid/out_stall lse_pkg::out_item_t (pixel and status)
// cfg       input      cfg_write           cfg_index, cfg_data (bit counts)
//
// One transaction is taken each cycle unless in_stall is high, into the input register;
// its result goes to the output register as the bit buffer and fill count are updated.
// Synchronous reset empties the buffer, clears the done flag and sets all counts to three.
// A stalled result holds the output register; the input stalls only when both the input
// register and the output register are full.

module lsb_stego_pixel_embed_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  lse_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lse_pkg::out_item_t out_data,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data
);

  logic                pipe_valid;
  lse_pkg::in_item_t   pipe_item;
  lse_pkg::cfg_t       cfg;
  lse_pkg::msg_state_t state;
  lse_pkg::msg_state_t state_next;
  lse_pkg::out_item_t  result;
  logic                advance;

  assign advance  = pipe_valid && (!out_valid || !out_stall);
  assign in_stall = pipe_valid && out_valid && out_stall;

  lse_embed u_embed (
    .cfg     (cfg),
    .st      (state),
    .item    (pipe_item),
    .result  (result),
    .st_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
      out_valid  <= 1'b0;
      state      <= '0;
    end else begin
      if (!in_stall) begin
        pipe_valid <= in_valid;
      end
      if (advance) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (!in_stall && in_valid) begin
      pipe_item <= in_data;
    end
    if (advance) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.red_bits   <= lse_pkg::BITS_RESET;
      cfg.green_bits <= lse_pkg::BITS_RESET;
      cfg.blue_bits  <= lse_pkg::BITS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lse_pkg::REG_RED_BITS:   cfg.red_bits   <= cfg_data;
        lse_pkg::REG_GREEN_BITS: cfg.green_bits <= cfg_data;
        lse_pkg::REG_BLUE_BITS:  cfg.blue_bits  <= cfg_data;
        default: ;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    state.fill <= lse_pkg::FILL_W'(lse_pkg::BUFFER_BITS))
    else $error("bit fill exceeds buffer size");

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    state.done |=> state.done)
    else $error("message done flag cleared outside reset");

  a_spent_stays_empty: assert property (@(posedge clk) disable iff (rst)
    (state.done && (state.fill == '0)) |=> (state.fill == '0))
    else $error("bits appeared after the message was used up");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (pipe_valid && out_valid && out_stall))
    else $error("input stalled without a blocked result");

endmodule

### test/lsb_stego_pixel_embed_unit_test.sv
`timescale 1ns / 1ps

module lsb_stego_pixel_embed_unit_test;

  localparam int LIMIT_CYCLES = 200000;
  localparam int IN_BITS      = $bits(lse_pkg::in_item_t);

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  lse_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  lse_pkg::out_item_t out_data;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = lse_pkg::REG_RED_BITS;
  logic [3:0]         cfg_data = 4'd0;

  lsb_stego_pixel_embed_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow copy of the embedder: configuration and message state.
  logic [3:0]  red_k = lse_pkg::BITS_RESET;
  logic [3:0]  green_k = lse_pkg::BITS_RESET;
  logic [3:0]  blue_k = lse_pkg::BITS_RESET;
  logic [63:0] msg_buf = '0;
  int          msg_fill = 0;
  bit          msg_done = 1'b0;

  lse_pkg::out_item_t pending_results[$];
  int        mismatches = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_request = 0;
  int        hold_left = 0;

  function automatic logic [63:0] low_ones(int n);
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic int clamp_count(logic [3:0] v);
    return (v > 4'd8) ? 8 : int'(v);
  endfunction

  function automatic int pixel_need();
    return clamp_count(red_k) + clamp_count(green_k) + clamp_count(blue_k);
  endfunction

  function automatic logic [7:0] take_bits(int k);
    logic [63:0] v;
    if (k == 0) return 8'd0;
    if (msg_fill >= k) begin
      v = (msg_buf >> (msg_fill - k)) & low_ones(k);
      msg_fill -= k;
    end else begin
      v = (msg_buf & low_ones(msg_fill)) << (k - msg_fill);
      msg_fill = 0;
    end
    msg_buf &= low_ones(msg_fill);
    return v[7:0];
  endfunction

  function automatic logic [7:0] embed_channel(logic [7:0] px, int k);
    logic [7:0] m;
    m = 8'(low_ones(k));
    return (px & ~m) | take_bits(k);
  endfunction

  function automatic lse_pkg::out_item_t stego_result(lse_pkg::in_item_t it);
    lse_pkg::out_item_t r;
    r = '0;
    if (!it.action) begin
      if (msg_done || msg_fill + 8 > lse_pkg::BUFFER_BITS) begin
        r.status = lse_pkg::ST_BYTE_REJ;
      end else begin
        msg_buf = ((msg_buf << 8) | 64'(it.message_byte)) & low_ones(lse_pkg::BUFFER_BITS);
        msg_fill += 8;
        if (it.message_last) msg_done = 1'b1;
        r.status = lse_pkg::ST_BYTE_OK;
      end
    end else if (msg_done && msg_fill == 0) begin
      r.red_out = it.red_in;
      r.green_out = it.green_in;
      r.blue_out = it.blue_in;
      r.status = lse_pkg::ST_DONE;
    end else if (msg_fill >= pixel_need() || msg_done) begin
      r.red_out = embed_channel(it.red_in, clamp_count(red_k));
      r.green_out = embed_channel(it.green_in, clamp_count(green_k));
      r.blue_out = embed_channel(it.blue_in, clamp_count(blue_k));
      r.status = lse_pkg::ST_EMBEDDED;
    end else begin
      r.red_out = it.red_in;
      r.green_out = it.green_in;
      r.blue_out = it.blue_in;
      r.status = lse_pkg::ST_UNDERRUN;
    end
    return r;
  endfunction

  function automatic lse_pkg::in_item_t random_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return lse_pkg::in_item_t'(raw[IN_BITS-1:0]);
  endfunction

  function automatic lse_pkg::in_item_t make_push(logic [7:0] b, logic last);
    lse_pkg::in_item_t it;
    it = random_item();
    it.action = 1'b0;
    it.message_byte = b;
    it.message_last = last;
    return it;
  endfunction

  function automatic lse_pkg::in_item_t make_pixel(logic [7:0] r, logic [7:0] g,
                                                   logic [7:0] b);
    lse_pkg::in_item_t it;
    it = random_item();
    it.action = 1'b1;
    it.red_in = r;
    it.green_in = g;
    it.blue_in = b;
    return it;
  endfunction

  // Mostly well-formed traffic that keeps the buffer fed, with some noise.
  // A last mark is only ever offered on a push that the full buffer rejects.
  function automatic lse_pkg::in_item_t next_random_item();
    lse_pkg::in_item_t it;
    bit full;
    full = (msg_fill + 8 > lse_pkg::BUFFER_BITS);
    if ($urandom_range(99) < 15) begin
      it = random_item();
      if (!it.action) it.message_last = full ? it.message_last : 1'b0;
    end else if (msg_fill < pixel_need() || (!full && $urandom_range(99) < 45)) begin
      it = make_push(8'($urandom), 1'b0);
    end else begin
      it = make_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end
    return it;
  endfunction

  task automatic send_item(lse_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(stego_result(it));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_counts(logic [3:0] r, logic [3:0] g, logic [3:0] b);
    wait_drained();
    cfg_write = 1'b1;
    cfg_index = lse_pkg::REG_RED_BITS;
    cfg_data = r;
    @(negedge clk);
    cfg_index = lse_pkg::REG_GREEN_BITS;
    cfg_data = g;
    @(negedge clk);
    cfg_index = lse_pkg::REG_BLUE_BITS;
    cfg_data = b;
    @(negedge clk);
    cfg_write = 1'b0;
    red_k = r;
    green_k = g;
    blue_k = b;
  endtask

  task automatic pick_counts();
    case ($urandom_range(7))
      0: set_counts(4'd0, 4'd0, 4'd0);
      1: set_counts(4'd8, 4'd8, 4'd8);
      2: set_counts(4'd15, 4'd15, 4'd15);
      3: set_counts(4'd1, 4'd0, 4'd8);
      default: set_counts(4'($urandom), 4'($urandom), 4'($urandom));
    endcase
  endtask

  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    lse_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result r=%02h g=%02h b=%02h status=%0d", $time,
                 out_data.red_out, out_data.green_out, out_data.blue_out, out_data.status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_data !== want) begin
          $display("%0t: mismatch expected r=%02h g=%02h b=%02h status=%0d", $time,
                   want.red_out, want.green_out, want.blue_out, want.status);
          $display("%0t:          actual   r=%02h g=%02h b=%02h status=%0d", $time,
                   out_data.red_out, out_data.green_out, out_data.blue_out,
                   out_data.status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(make_pixel(8'h00, 8'h00, 8'h00));
    send_item(make_pixel(8'hFF, 8'hFF, 8'hFF));
    send_item(make_push(8'hFF, 1'b0));
    send_item(make_push(8'h00, 1'b0));
    send_item(make_push(8'hA5, 1'b0));
    send_item(make_push(8'h5A, 1'b0));
    // The buffer is full, so this push and its last mark must be dropped.
    send_item(make_push(8'hC3, 1'b1));
    send_item(make_pixel(8'hFF, 8'hFF, 8'hFF));
    send_item(make_pixel(8'h00, 8'h00, 8'h00));
    set_counts(4'd0, 4'd0, 4'd0);
    send_item(make_pixel(8'h12, 8'h34, 8'h56));
    send_item(make_push(8'hFF, 1'b0));
    set_counts(4'd8, 4'd8, 4'd8);
    send_item(make_pixel(8'hAA, 8'h55, 8'hAA));
    send_item(make_push(8'hFF, 1'b0));
    send_item(make_pixel(8'h00, 8'hFF, 8'h00));
    set_counts(4'd15, 4'd15, 4'd15);
    send_item(make_push(8'h81, 1'b0));
    send_item(make_pixel(8'hFF, 8'h00, 8'hFF));
    set_counts(4'd8, 4'd0, 4'd1);
    send_item(make_pixel(8'h7F, 8'h80, 8'hFE));
    send_item(make_pixel(8'h80, 8'h7F, 8'h01));
  endtask

  task automatic test_random_phase(int sender_pct, int receiver_pct, int count);
    send_idle_pct = sender_pct;
    recv_stall_pct = receiver_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 110 == 0) pick_counts();
      send_item(next_random_item());
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 10;
    set_counts(4'd2, 4'd3, 4'd1);
    hold_request = 300;
    for (int i = 0; i < 60; i++) send_item(next_random_item());
    wait_drained();
    for (int i = 0; i < 30; i++) send_item(next_random_item());
  endtask

  task automatic test_last_byte();
    send_idle_pct = 17;
    recv_stall_pct = 55;
    set_counts(4'd8, 4'd8, 4'd8);
    while (msg_fill >= 24) send_item(make_pixel(8'($urandom), 8'($urandom), 8'($urandom)));
    if (msg_fill == 16) begin
      send_item(make_push(8'($urandom), 1'b0));
      send_item(make_pixel(8'($urandom), 8'($urandom), 8'($urandom)));
    end
    send_item(make_push(8'($urandom), 1'b1));
    // The last of these pixels is short and takes zero padding.
    while (msg_fill > 0) send_item(make_pixel(8'($urandom), 8'($urandom), 8'($urandom)));
    send_item(make_pixel(8'hFF, 8'h00, 8'hFF));
    send_item(make_push(8'h3C, 1'b0));
    send_item(make_push(8'hC3, 1'b1));
    set_counts(4'd3, 4'd3, 4'd3);
    for (int i = 0; i < 30; i++) send_item(random_item());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    send_idle_pct = 17;
    recv_stall_pct = 55;
    test_directed();
    test_random_phase(17, 55, 650);
    test_random_phase(55, 17, 650);
    test_random_phase(0, 0, 650);
    test_backpressure();
    test_last_byte();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
